// ----- sv/assert_macros.svh -----
// Shared assertion macros for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/u8d_pkg.sv -----
package u8d_pkg;

  // Continuation bytes still expected for the pending character.
  typedef logic [2:0] rem_t;

  // Decoded character value.
  typedef logic [30:0] cp_t;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContTag   = 8'h80;
  localparam logic [7:0] Lead2Min  = 8'hC0;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead5Min  = 8'hF8;
  localparam logic [7:0] Lead6Min  = 8'hFC;
  localparam logic [7:0] BadLeadMin = 8'hFE;

  localparam rem_t RemIdle = 3'd0;
  localparam rem_t RemLast = 3'd1;
  localparam rem_t RemMax  = 3'd5;

endpackage

// ----- sv/utf8_stream_decoder.sv -----
// UTF-8 stream decoder for the original 1-to-6-byte form. One byte is taken
// per beat, and a new byte can be accepted every cycle while the result side
// keeps up. The byte register captures the byte at its accepting edge. The
// decode is combinational into the result register, which loads while its
// slot is free; a completing byte passes the byte register, then the result
// register. A held result stalls the input only when the byte register is
// also full. Lead bytes 0x00-0xBF give an immediate result (byte AND 0x7F).
// 0xFE and 0xFF give an immediate error, and longer characters give one result
// on their last byte. A malformed continuation byte drops the pending character
// and the byte itself, and yields an error result with code point zero.
// Overlong forms and surrogates are passed through unchecked.
`include "assert_macros.svh"

module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [30:0] code_point_o,
  output logic        error_o
);

  logic              s1_valid_q;
  logic [7:0]        byte_q;
  u8d_pkg::rem_t     rem_q, rem_d;
  u8d_pkg::cp_t      part_q, part_d;
  logic              out_valid_q;
  u8d_pkg::cp_t      cp_q;
  logic              err_q;

  logic              out_free;
  logic              proc;
  logic              res_fire;
  u8d_pkg::cp_t      res_cp;
  logic              res_err;
  u8d_pkg::cp_t      ext;

  // Result slot frees when empty or drained this cycle.
  assign out_free   = !out_valid_q || out_ready_i;
  assign proc       = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;

  // Shift six payload bits into the pending value.
  assign ext = {part_q[24:0], byte_q[5:0]};

  // Decode the registered byte against the pending character.
  always_comb begin
    res_fire = 1'b0;
    res_cp   = '0;
    res_err  = 1'b0;
    rem_d    = rem_q;
    part_d   = part_q;
    if (rem_q != u8d_pkg::RemIdle) begin
      if ((byte_q & u8d_pkg::ContMask) != u8d_pkg::ContTag) begin
        res_fire = 1'b1;
        res_err  = 1'b1;
        rem_d    = u8d_pkg::RemIdle;
        part_d   = '0;
      end else begin
        rem_d = rem_q - 3'd1;
        if (rem_q == u8d_pkg::RemLast) begin
          res_fire = 1'b1;
          res_cp   = ext;
          part_d   = '0;
        end else begin
          part_d = ext;
        end
      end
    end else if (byte_q >= u8d_pkg::BadLeadMin) begin
      res_fire = 1'b1;
      res_err  = 1'b1;
    end else if (byte_q < u8d_pkg::Lead2Min) begin
      res_fire = 1'b1;
      res_cp   = {24'd0, byte_q[6:0]};
    end else if (byte_q < u8d_pkg::Lead3Min) begin
      part_d = {26'd0, byte_q[4:0]};
      rem_d  = 3'd1;
    end else if (byte_q < u8d_pkg::Lead4Min) begin
      part_d = {27'd0, byte_q[3:0]};
      rem_d  = 3'd2;
    end else if (byte_q < u8d_pkg::Lead5Min) begin
      part_d = {28'd0, byte_q[2:0]};
      rem_d  = 3'd3;
    end else if (byte_q < u8d_pkg::Lead6Min) begin
      part_d = {29'd0, byte_q[1:0]};
      rem_d  = 3'd4;
    end else begin
      part_d = {30'd0, byte_q[0]};
      rem_d  = u8d_pkg::RemMax;
    end
  end

  // Hold the input beat until it is decoded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
  end

  // Advance decoder state once per decoded byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= u8d_pkg::RemIdle;
      part_q <= '0;
    end else if (proc) begin
      rem_q  <= rem_d;
      part_q <= part_d;
    end
  end

  // Load the result register; drop bytes that complete nothing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc && res_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && res_fire) begin
      cp_q  <= res_cp;
      err_q <= res_err;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = cp_q;
  assign error_o      = err_q;

  `ASSERT_IMPLIES(a_err_zero_cp, clk_i, rst_ni, out_valid_q && err_q, cp_q == '0, "cp on error")
  `ASSERT_ALWAYS(a_rem_range, clk_i, rst_ni, rem_q <= u8d_pkg::RemMax, "count out of range")
  `ASSERT_IMPLIES(a_idle_clear, clk_i, rst_ni, rem_q == u8d_pkg::RemIdle, part_q == '0, "part kept")

endmodule

// ----- test/utf8_stream_decoder_tb.sv -----
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

  typedef struct packed {
    u8d_pkg::cp_t code_point;
    logic         error;
  } decoded_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_in_i    = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [30:0] code_point_o;
  logic        error_o;

  // Decoder state mirrored by the predictor
  u8d_pkg::rem_t rem_cnt    = u8d_pkg::RemIdle;
  u8d_pkg::cp_t  partial_cp = '0;
  decoded_t      expected_chars_q[$];

  int  fail_cnt    = 0;
  int  bytes_sent  = 0;
  bit  tx_idle_en  = 1'b1;
  bit  rx_idle_en  = 1'b1;
  int  stall_left  = 0;

  utf8_stream_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_in_i   (byte_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .code_point_o(code_point_o),
    .error_o     (error_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the decoder state by one byte; queue the character it completes
  function automatic void decode_byte(input logic [7:0] b);
    decoded_t r;
    bit       done;
    r    = '0;
    done = 1'b0;
    if (rem_cnt != u8d_pkg::RemIdle) begin
      if ((b & u8d_pkg::ContMask) != u8d_pkg::ContTag) begin
        // malformed continuation: drop the pending character and this byte
        rem_cnt    = u8d_pkg::RemIdle;
        partial_cp = '0;
        r.error    = 1'b1;
        done       = 1'b1;
      end else begin
        partial_cp = {partial_cp[24:0], b[5:0]};
        rem_cnt    = rem_cnt - u8d_pkg::rem_t'(1);
        if (rem_cnt == u8d_pkg::RemIdle) begin
          r.code_point = partial_cp;
          partial_cp   = '0;
          done         = 1'b1;
        end
      end
    end else if (b >= u8d_pkg::BadLeadMin) begin
      r.error = 1'b1;
      done    = 1'b1;
    end else if (b < u8d_pkg::Lead2Min) begin
      // plain ASCII, or a stray continuation taken as a lead
      r.code_point = {24'd0, b[6:0]};
      done         = 1'b1;
    end else if (b < u8d_pkg::Lead3Min) begin
      partial_cp = {26'd0, b[4:0]};
      rem_cnt    = u8d_pkg::RemLast;
    end else if (b < u8d_pkg::Lead4Min) begin
      partial_cp = {27'd0, b[3:0]};
      rem_cnt    = u8d_pkg::rem_t'(2);
    end else if (b < u8d_pkg::Lead5Min) begin
      partial_cp = {28'd0, b[2:0]};
      rem_cnt    = u8d_pkg::rem_t'(3);
    end else if (b < u8d_pkg::Lead6Min) begin
      partial_cp = {29'd0, b[1:0]};
      rem_cnt    = u8d_pkg::rem_t'(4);
    end else begin
      partial_cp = {30'd0, b[0]};
      rem_cnt    = u8d_pkg::RemMax;
    end
    if (done) expected_chars_q.push_back(r);
  endfunction

  // Predict on each accepted byte, then compare each accepted result
  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) decode_byte(byte_in_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_chars_q.size() == 0) begin
          $error("unexpected result: code_point %h error %b", code_point_o, error_o);
          fail_cnt++;
        end else begin
          want = expected_chars_q.pop_front();
          if (code_point_o !== want.code_point) begin
            $error("code_point mismatch: expected %h, got %h", want.code_point, code_point_o);
            fail_cnt++;
          end
          if (error_o !== want.error) begin
            $error("error mismatch: expected %b, got %b", want.error, error_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Stall the result side in short random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 3);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Send one beat; valid stays high on return so the next beat can follow at once
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    bytes_sent++;
  endtask

  task automatic hold_input();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (expected_chars_q.size() != 0);
  endtask

  // Field extremes, stray continuation, invalid leads
  task automatic test_single_bytes();
    send_byte(8'h00);
    send_byte(8'hBF);
    send_byte(8'hFE);
    send_byte(8'hFF);
  endtask

  // Two- to five-byte characters with extreme payloads
  task automatic test_full_chars();
    send_byte(8'hDF); send_byte(8'hBF);
    send_byte(8'hEF); send_byte(8'h80); send_byte(8'hBF);
    send_byte(8'hF7); send_byte(8'hBF); send_byte(8'hBF); send_byte(8'hBF);
    send_byte(8'hFB);
    repeat (4) send_byte(8'h80);
  endtask

  // Broken continuations, including one inside a six-byte character
  task automatic test_malformed();
    send_byte(8'hC1); send_byte(8'h41);
    send_byte(8'hFC); send_byte(8'hBF); send_byte(8'hC3);
    send_byte(8'h41);
  endtask

  // One character of random content; sometimes noise or a broken sequence
  task automatic send_random_char();
    int         len;
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) begin
      send_byte(8'($urandom_range(0, 255)));
      return;
    end
    len = $urandom_range(1, 6);
    b   = 8'($urandom());
    case (len)
      1: send_byte(8'($urandom_range(0, 8'hBF)));
      2: send_byte(u8d_pkg::Lead2Min | {3'b000, b[4:0]});
      3: send_byte(u8d_pkg::Lead3Min | {4'h0, b[3:0]});
      4: send_byte(u8d_pkg::Lead4Min | {5'd0, b[2:0]});
      5: send_byte(u8d_pkg::Lead5Min | {6'd0, b[1:0]});
      default: send_byte(u8d_pkg::Lead6Min | {7'd0, b[0]});
    endcase
    for (int i = 1; i < len; i++) begin
      b = 8'($urandom());
      if ($urandom_range(0, 19) == 0) begin
        // break the sequence with a byte that is not a continuation
        if ((b & u8d_pkg::ContMask) == u8d_pkg::ContTag) b[6] = 1'b1;
        send_byte(b);
        return;
      end
      send_byte(u8d_pkg::ContTag | {2'b00, b[5:0]});
    end
  endtask

  // Random traffic with idle stretches switched on and off, and drain pauses
  task automatic test_random_traffic(input int n_bytes);
    int target;
    int next_switch;
    int next_pause;
    target      = bytes_sent + n_bytes;
    next_switch = bytes_sent;
    next_pause  = bytes_sent + 150;
    while (bytes_sent < target) begin
      if (bytes_sent >= next_switch) begin
        tx_idle_en  = ($urandom_range(0, 2) != 0);
        rx_idle_en  = ($urandom_range(0, 2) != 0);
        next_switch = bytes_sent + 100;
      end
      if (bytes_sent >= next_pause) begin
        hold_input();
        wait_drained();
        next_pause = bytes_sent + 250;
      end
      send_random_char();
    end
  endtask

  // Full rate on both sides to close the run
  task automatic test_back_to_back(input int n_bytes);
    int target;
    target     = bytes_sent + n_bytes;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (bytes_sent < target) send_random_char();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_bytes();
    test_full_chars();
    test_malformed();
    test_random_traffic(700);
    test_back_to_back(400);
    hold_input();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && expected_chars_q.size() == 0) begin
      $display("utf8_stream_decoder_tb OK");
    end else begin
      $display("utf8_stream_decoder_tb NOT OK");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #2ms;
    $display("utf8_stream_decoder_tb NOT OK");
    $finish;
  end

endmodule
